FILE: design/crq_pkg.sv
// Shared types and constants for the CAN receive message queue.
`timescale 1ns / 1ps
`default_nettype none

package crq_pkg;

  localparam int unsigned QCOUNT_W = 4;
  localparam int unsigned MAX_LEN  = 8;

  // Input item kinds
  typedef enum logic [2:0] {
    KIND_FRAME       = 3'd0,
    KIND_POP         = 3'd1,
    KIND_OVERRUN     = 3'd2,
    KIND_STATUS_READ = 3'd3,
    KIND_START       = 3'd4
  } kind_t;

  // Commands handed from the front to the back
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_OVERRUN,
    OP_STATUS_READ,
    OP_START,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    LINK_STOPPED = 2'd0,
    LINK_READY   = 2'd1,
    LINK_OVERRUN = 2'd2
  } link_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] rx_ident_word;
    logic [31:0] rx_length_word;
    logic [31:0] rx_data_low;
    logic [31:0] rx_data_high;
    logic        rx_fifo;
  } in_item_t;

  typedef struct packed {
    logic        push_accepted;
    logic        msg_valid;
    logic [10:0] msg_ident;
    logic [3:0]  msg_length;
    logic [7:0]  msg_filter;
    logic        msg_fifo;
    logic [31:0] msg_data_low;
    logic [31:0] msg_data_high;
    logic [1:0]  link_status;
    logic [QCOUNT_W-1:0] queue_count;
  } out_item_t;

  typedef struct packed {
    logic        fifo;
    logic [7:0]  filter;
    logic [3:0]  length;
    logic [10:0] ident;
  } msg_header_t;

  typedef struct packed {
    msg_header_t header;
    logic [31:0] data_high;
    logic [31:0] data_low;
  } msg_entry_t;

  typedef struct packed {
    op_t        op;
    msg_entry_t entry;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/crq_front.sv
// Front end: decodes an item, extracts and masks the frame, queues the command.
`timescale 1ns / 1ps
`default_nettype none

module crq_front
  import crq_pkg::*;
(
  input  wire logic     start,
  input  wire in_item_t item,
  input  wire logic     cmdq_full,
  output logic          busy,
  output logic          cmdq_push,
  output cmd_t          cmd
);

  logic [3:0] len;

  assign busy      = cmdq_full;
  assign cmdq_push = start && !cmdq_full;

  // Clamp oversized lengths to a full frame
  assign len = (item.rx_length_word[3:0] > 4'(MAX_LEN)) ? 4'(MAX_LEN)
                                                        : item.rx_length_word[3:0];

  always_comb begin
    cmd = '0;
    unique case (item.kind)
      KIND_FRAME:       cmd.op = OP_PUSH;
      KIND_POP:         cmd.op = OP_POP;
      KIND_OVERRUN:     cmd.op = OP_OVERRUN;
      KIND_STATUS_READ: cmd.op = OP_STATUS_READ;
      KIND_START:       cmd.op = OP_START;
      default:          cmd.op = OP_NONE;
    endcase
    cmd.entry.header.ident  = item.rx_ident_word[31:21];
    cmd.entry.header.length = len;
    cmd.entry.header.filter = item.rx_length_word[15:8];
    cmd.entry.header.fifo   = item.rx_fifo;
    // Zero the bytes past the length
    for (int b = 0; b < 4; b++) begin
      if (4'(b) < len) begin
        cmd.entry.data_low[8*b +: 8]  = item.rx_data_low[8*b +: 8];
      end
      if (4'(b + 4) < len) begin
        cmd.entry.data_high[8*b +: 8] = item.rx_data_high[8*b +: 8];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/crq_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module crq_cmd_fifo
  import crq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/crq_back.sv
// Back end: message ring memory, pointers, link status and result register.
`timescale 1ns / 1ps
`default_nettype none

module crq_back
  import crq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_avail,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      done,
  output out_item_t result
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  msg_entry_t   ring [QUEUE_DEPTH];
  msg_entry_t   rd_entry;
  back_state_t  state, state_next;
  link_status_t status, status_next;
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic         mem_we;
  logic         mem_re;
  logic         res_load;
  out_item_t    res_next;
  logic         full;
  logic         empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

  assign full  = (entry_count == CNT_W'(QUEUE_DEPTH));
  assign empty = (entry_count == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (cmd_avail && cmd.op == OP_POP && !empty) begin
        state_next = BK_READ;
      end
      BK_READ: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_take           = 1'b0;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    res_load           = 1'b0;
    res_next           = '0;
    status_next        = status;
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    entry_count_next   = entry_count;
    unique case (state)
      BK_IDLE: if (cmd_avail) begin
        cmd_take = 1'b1;
        res_load = 1'b1;
        unique case (cmd.op)
          OP_PUSH: if (!full) begin
            mem_we                 = 1'b1;
            write_pointer_next     = ptr_inc(write_pointer);
            entry_count_next       = entry_count + CNT_W'(1);
            res_next.push_accepted = 1'b1;
          end
          OP_POP: if (!empty) begin
            // Result goes out once the ring read returns
            mem_re            = 1'b1;
            res_load          = 1'b0;
            read_pointer_next = ptr_inc(read_pointer);
            entry_count_next  = entry_count - CNT_W'(1);
          end
          OP_OVERRUN:     status_next = LINK_OVERRUN;
          OP_START:       status_next = LINK_READY;
          OP_STATUS_READ: if (status == LINK_OVERRUN) begin
            status_next = LINK_READY;
          end
          default: ;
        endcase
        // A status read shows the value before the clear
        res_next.link_status = (cmd.op == OP_STATUS_READ) ? status : status_next;
        res_next.queue_count = QCOUNT_W'(entry_count_next);
      end
      BK_READ: begin
        res_load               = 1'b1;
        res_next.msg_valid     = 1'b1;
        res_next.msg_ident     = rd_entry.header.ident;
        res_next.msg_length    = rd_entry.header.length;
        res_next.msg_filter    = rd_entry.header.filter;
        res_next.msg_fifo      = rd_entry.header.fifo;
        res_next.msg_data_low  = rd_entry.data_low;
        res_next.msg_data_high = rd_entry.data_high;
        res_next.link_status   = status;
        res_next.queue_count   = QCOUNT_W'(entry_count);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[write_pointer] <= cmd.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_entry <= ring[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      status        <= LINK_STOPPED;
      write_pointer <= '0;
      read_pointer  <= '0;
      entry_count   <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      status        <= status_next;
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      entry_count   <= entry_count_next;
      done          <= res_load;
    end
  end

endmodule

`default_nettype wire

FILE: design/can_receive_message_queue.sv
// Top level of the CAN receive message queue.
`timescale 1ns / 1ps
`default_nettype none

// Receive message queue for CAN frames with a link status flag. An item is
// taken on a clock edge with start high and busy low; each item gives exactly
// one result, shown on result for one cycle while done is high, and the
// receiver must take it then. The front end decodes and masks the frame and
// drops a command into a two-entry queue; busy is high only while that queue
// is full. The back end retires one command per cycle, except a pop that
// finds an entry, which also passes through the BK_READ state because the
// ring memory has a registered read port. With nothing queued ahead, done
// rises once the item has passed the command queue and the result register,
// and the ring read register for such a pop. QUEUE_DEPTH sets the ring's depth in frames.
module can_receive_message_queue
  import crq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_item_t item,
  output logic          busy,
  output logic          done,
  output out_item_t     result
);

  logic cmdq_full;
  logic cmdq_push;
  logic cmdq_not_empty;
  logic cmdq_pop;
  cmd_t front_cmd;
  cmd_t head_cmd;

  crq_front u_front (
    .start     (start),
    .item      (item),
    .cmdq_full (cmdq_full),
    .busy      (busy),
    .cmdq_push (cmdq_push),
    .cmd       (front_cmd)
  );

  crq_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (cmdq_push),
    .push_cmd  (front_cmd),
    .pop       (cmdq_pop),
    .full      (cmdq_full),
    .not_empty (cmdq_not_empty),
    .head      (head_cmd)
  );

  crq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (cmdq_not_empty),
    .cmd       (head_cmd),
    .cmd_take  (cmdq_pop),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire
